[rtl/core/assert_macros.svh]
// Assertion macros shared by the checker files of this block.
// No dependencies; take in with `include before use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, held off while reset is low.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that the antecedent implies the consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  `ASSERT_PROP(label, clk, rst_n, (ante) |-> (cons), msg)

// Check that the antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  `ASSERT_PROP(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

[rtl/core/txdr_pkg.sv]
// Types and fixed constants of the transmit descriptor ring producer.
// No dependencies; compile before all other files of the block.
`timescale 1ns / 1ps

package txdr_pkg;

  localparam int unsigned IDX_W   = 16;
  localparam int unsigned SLOT_W  = 15;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned ADDR_W  = 49;
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned APB_AW  = 4;
  localparam int unsigned APB_DW  = 64;

  localparam int unsigned BUFFER_BYTES   = 2048;
  localparam int unsigned BUF_SHIFT      = $clog2(BUFFER_BYTES);
  localparam int unsigned DOORBELL_CHUNK = 128;
  localparam int unsigned MIN_LENGTH     = 6;

  localparam logic [IDX_W-1:0] RING_ENTRIES_RST = 16'd1024;

  // Descriptor word layout
  localparam int unsigned TYPE_LSB    = 60;
  localparam int unsigned HDR_CNT_LSB = 48;
  localparam logic [3:0]  HDR_TYPE    = 4'h1;
  localparam logic [3:0]  GTH_TYPE    = 4'h4;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_QUEUED  = 2'd0;
  localparam logic [STAT_W-1:0] ST_SHORT   = 2'd1;
  localparam logic [STAT_W-1:0] ST_LONG    = 2'd2;
  localparam logic [STAT_W-1:0] ST_NO_ROOM = 2'd3;

  // Register indexes, taken from paddr[3] (byte address 8*i)
  localparam logic REG_RING_ENTRIES = 1'b0;
  localparam logic REG_BUFFER_BASE  = 1'b1;

  typedef struct packed {
    logic [IDX_W-1:0] producer_slot;
    logic [IDX_W-1:0] batch_budget;
    logic [IDX_W-1:0] batch_used;
    logic [IDX_W-1:0] doorbell_acc;
  } ring_state_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot_index;
    logic [WORD_W-1:0] header_word;
    logic [WORD_W-1:0] gather_word;
    logic [ADDR_W-1:0] gather_address;
    logic              ring_doorbell;
  } result_t;

endpackage

[rtl/core/txdr_step.sv]
// Per-item logic: budget, length checks, descriptor packing, index update.
// Depends on txdr_pkg.
`timescale 1ns / 1ps

module txdr_step (
  input  txdr_pkg::ring_state_t              state,
  input  logic [txdr_pkg::IDX_W-1:0]         ring_entries,
  input  logic [txdr_pkg::ADDR_W-1:0]        buffer_base,
  input  logic [txdr_pkg::LEN_W-1:0]         packet_length,
  input  logic [txdr_pkg::IDX_W-1:0]         consumer_index,
  input  logic                               batch_start,
  input  logic                               batch_end,
  output txdr_pkg::ring_state_t              state_nxt,
  output txdr_pkg::result_t                  result
);
  import txdr_pkg::*;

  logic [IDX_W-1:0]  budget;
  logic [IDX_W-1:0]  used;
  logic [IDX_W-1:0]  fresh_budget;
  logic              no_room;
  logic              too_short;
  logic              too_long;
  logic              queued;
  logic [IDX_W-1:0]  slot_plus2;
  logic [IDX_W-1:0]  used_after;
  logic [IDX_W-1:0]  acc_sum;
  logic              bell;
  logic [ADDR_W-1:0] offset;

  always_comb begin
    fresh_budget = (ring_entries - IDX_W'(2) - state.producer_slot + consumer_index)
                 & (ring_entries - IDX_W'(1));
    budget = batch_start ? fresh_budget : state.batch_budget;
    used   = batch_start ? '0 : state.batch_used;

    no_room   = (used >= budget);
    too_short = (packet_length < LEN_W'(MIN_LENGTH));
    too_long  = ({1'b0, packet_length} > (LEN_W+1)'(BUFFER_BYTES));
    queued    = !no_room && !too_short && !too_long;

    slot_plus2 = state.producer_slot + IDX_W'(2);
    used_after = queued ? (used + IDX_W'(2)) : used;
    acc_sum    = state.doorbell_acc + used_after;
    bell       = batch_end && (acc_sum > IDX_W'(DOORBELL_CHUNK));

    offset = ADDR_W'(state.producer_slot[IDX_W-1:1]) << BUF_SHIFT;

    state_nxt.batch_budget  = budget;
    state_nxt.batch_used    = used_after;
    state_nxt.producer_slot = state.producer_slot;
    if (queued) begin
      state_nxt.producer_slot = (slot_plus2 >= ring_entries) ? '0 : slot_plus2;
    end
    state_nxt.doorbell_acc = state.doorbell_acc;
    if (batch_end) begin
      state_nxt.doorbell_acc = bell ? (acc_sum - IDX_W'(DOORBELL_CHUNK)) : acc_sum;
    end

    // Room check takes priority over the length checks
    if (no_room) begin
      result.status = ST_NO_ROOM;
    end else if (too_short) begin
      result.status = ST_SHORT;
    end else if (too_long) begin
      result.status = ST_LONG;
    end else begin
      result.status = ST_QUEUED;
    end

    result.slot_index     = '0;
    result.header_word    = '0;
    result.gather_word    = '0;
    result.gather_address = '0;
    if (queued) begin
      result.slot_index  = state.producer_slot[SLOT_W-1:0];
      result.header_word = (WORD_W'(HDR_TYPE) << TYPE_LSB)
                         | (WORD_W'(1) << HDR_CNT_LSB)
                         | WORD_W'(packet_length);
      result.gather_word = (WORD_W'(GTH_TYPE) << TYPE_LSB) | WORD_W'(packet_length);
      result.gather_address = buffer_base + offset;
    end
    result.ring_doorbell = bell;
  end

endmodule

[rtl/core/tx_descriptor_ring_producer.sv]
// Top level of the transmit descriptor ring producer: ring state, config
// registers and the output stage. Depends on txdr_pkg and txdr_step.
`timescale 1ns / 1ps

//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------------------
//  in_     | input     | in_valid / in_ready     | packet_length, consumer_index,
//          |           |                         | batch_start, batch_end
//  out_    | output    | out_valid / out_ready   | status, slot_index, header_word,
//          |           |                         | gather_word, gather_address, ring_doorbell
//  cfg_    | input     | APB write, pready = 1   | ring_entries (0x0), buffer_base (0x8)
//
//  Each item's result is registered at the accepting edge, and the ring state
//  advances at that same edge, so items go back to back while in_ready is high.
//  The only loop is the ring state feeding the per-item logic.
//  Reset is synchronous, active low, and clears the ring state and the valid bits.
//  A stalled output parks one result in a skid register; in_ready drops only
//  while that register holds an item, so it never depends on out_ready.

module tx_descriptor_ring_producer (
  input  logic                               clk,
  input  logic                               rst_n,

  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [txdr_pkg::LEN_W-1:0]         in_packet_length,
  input  logic [txdr_pkg::IDX_W-1:0]         in_consumer_index,
  input  logic                               in_batch_start,
  input  logic                               in_batch_end,

  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [txdr_pkg::STAT_W-1:0]        out_status,
  output logic [txdr_pkg::SLOT_W-1:0]        out_slot_index,
  output logic [txdr_pkg::WORD_W-1:0]        out_header_word,
  output logic [txdr_pkg::WORD_W-1:0]        out_gather_word,
  output logic [txdr_pkg::ADDR_W-1:0]        out_gather_address,
  output logic                               out_ring_doorbell,

  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [txdr_pkg::APB_AW-1:0]        cfg_paddr,
  input  logic [txdr_pkg::APB_DW-1:0]        cfg_pwdata,
  output logic [txdr_pkg::APB_DW-1:0]        cfg_prdata,
  output logic                               cfg_pready
);
  import txdr_pkg::*;

  // Config registers
  logic [IDX_W-1:0]  ring_entries_r;
  logic [ADDR_W-1:0] buffer_base_r;
  logic              cfg_wr;
  logic              cfg_sel;

  // Ring state
  ring_state_t state_r;
  ring_state_t state_nxt;
  result_t     step_res;

  // Output stage: main register plus one skid register
  logic    out_valid_r;
  logic    skid_valid_r;
  result_t out_data_r;
  result_t skid_data_r;
  logic    in_fire;
  logic    out_fire;

  assign cfg_pready = 1'b1;
  assign cfg_sel    = cfg_paddr[3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (cfg_sel)
      REG_RING_ENTRIES: cfg_prdata = APB_DW'(ring_entries_r);
      REG_BUFFER_BASE:  cfg_prdata = APB_DW'(buffer_base_r);
      default:          cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_entries_r <= RING_ENTRIES_RST;
      buffer_base_r  <= '0;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_RING_ENTRIES: ring_entries_r <= cfg_pwdata[IDX_W-1:0];
        REG_BUFFER_BASE:  buffer_base_r  <= cfg_pwdata[ADDR_W-1:0];
        default:          ;
      endcase
    end
  end

  txdr_step u_step (
    .state          (state_r),
    .ring_entries   (ring_entries_r),
    .buffer_base    (buffer_base_r),
    .packet_length  (in_packet_length),
    .consumer_index (in_consumer_index),
    .batch_start    (in_batch_start),
    .batch_end      (in_batch_end),
    .state_nxt      (state_nxt),
    .result         (step_res)
  );

  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;

  // Advance the ring state once per accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // Valid bits of the output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      // Drain the skid register into the free output slot
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid_r && !out_ready) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload of the output stage
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_data_r <= skid_data_r;
      end
    end else if (in_fire) begin
      if (out_valid_r && !out_ready) begin
        skid_data_r <= step_res;
      end else begin
        out_data_r <= step_res;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_data_r.status;
  assign out_slot_index     = out_data_r.slot_index;
  assign out_header_word    = out_data_r.header_word;
  assign out_gather_word    = out_data_r.gather_word;
  assign out_gather_address = out_data_r.gather_address;
  assign out_ring_doorbell  = out_data_r.ring_doorbell;

endmodule

[rtl/core/txdr_checker.sv]
// Port-level checks of the transmit descriptor ring producer, bound to the top.
// Depends on txdr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module txdr_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [txdr_pkg::STAT_W-1:0]        out_status,
  input logic [txdr_pkg::SLOT_W-1:0]        out_slot_index,
  input logic [txdr_pkg::WORD_W-1:0]        out_header_word,
  input logic [txdr_pkg::WORD_W-1:0]        out_gather_word
);
  import txdr_pkg::*;

  // With the output empty, nothing can be parked, so input must be open
  `ASSERT_SAME(a_ready_when_empty, clk, rst_n, !out_valid, in_ready, "in_ready low with output empty")

  // An item taken into an empty output stage shows up on the next cycle
  `ASSERT_NEXT(a_item_lands, clk, rst_n, in_valid && in_ready && !out_valid, out_valid, "accepted item lost")

  // A queued result carries matching lengths and descriptor types
  `ASSERT_SAME(a_queued_words, clk, rst_n, out_valid && (out_status == ST_QUEUED), (out_header_word[LEN_W-1:0] == out_gather_word[LEN_W-1:0]) && (out_header_word[WORD_W-1:TYPE_LSB] == HDR_TYPE) && (out_gather_word[WORD_W-1:TYPE_LSB] == GTH_TYPE), "queued descriptor words malformed")

  // Hold a stalled result
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_slot_index) && $stable(out_header_word), "stalled result changed")

endmodule

bind tx_descriptor_ring_producer txdr_checker u_txdr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status      (out_status),
  .out_slot_index  (out_slot_index),
  .out_header_word (out_header_word),
  .out_gather_word (out_gather_word)
);
